// ===== hw/rtl/brb_pkg.sv =====
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package brb_pkg;
	localparam int unsigned DEPTH_DEF     = 8;
	localparam int unsigned READERS_DEF   = 16;
	localparam int unsigned DATA_BITS_DEF = 32;

	localparam int unsigned COUNT_BITS = 8;
	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned RDR_BITS   = 4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic MODE_SEND = 1'b0;
	localparam logic MODE_RECV = 1'b1;

	typedef struct packed {
		logic capture;
		logic exec;
		logic flag;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic recv_go;
	} stat_t;
endpackage

// ===== hw/rtl/broadcast_ring_buffer.sv =====
// Top level: broadcast ring buffer with one writer and several read cursors.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; mode selects send (write data_in to the next slot) or receive (read the
// next unread word for cursor reader). Every request gives exactly one result,
// shown on status, data_out and slot_freed for one cycle while done is high.
// The receiver cannot stall; it must take each result in that cycle.
// Sequence of a request:
//   send, or a receive that finds nothing unread: result in the cycle after
//   the execute cycle, busy only during that execute cycle.
//   receive of a word: busy through execute, reader-count scan and finish;
//   the result follows. The scan of all reader counts against the word just
//   read adds the scan and finish steps. No new request is taken while busy.
// Busy falls while a result is shown, so the next request overlaps it.
// Reset: all slots free, write index, sent count and reader counts zero; no
// result is pending. Slot contents are not cleared.
`timescale 1ns / 1ps
module broadcast_ring_buffer
	import brb_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned READERS   = READERS_DEF,
	parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  logic [RDR_BITS-1:0]   reader,
	input  logic [WORD_BITS-1:0]  data_in,
	output logic                  done,
	output logic [1:0]            status,
	output logic [WORD_BITS-1:0]  data_out,
	output logic                  slot_freed
);
	cmd_t  cmd;
	stat_t stat;

	brb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	brb_dp #(
		.DEPTH     (DEPTH),
		.READERS   (READERS),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.reader     (reader),
		.data_in    (data_in),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.slot_freed (slot_freed)
	);
endmodule

// ===== hw/rtl/brb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module brb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/brb_ctrl.sv =====
// Controller: sequences accept, execute, pending check and finish steps.
`timescale 1ns / 1ps
module brb_ctrl
	import brb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.recv_go ? S_CHECK : S_IDLE;
			end
			S_CHECK: begin
				cmd.flag = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== hw/rtl/brb_dp.sv =====
// Datapath: slot store, slot flags, pointers, reader counts and result register.
`timescale 1ns / 1ps
module brb_dp
	import brb_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned READERS   = READERS_DEF,
	parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic                  mode,
	input  logic [RDR_BITS-1:0]   reader,
	input  logic [WORD_BITS-1:0]  data_in,
	output logic                  done,
	output logic [1:0]            status,
	output logic [WORD_BITS-1:0]  data_out,
	output logic                  slot_freed
);
	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned RI = (READERS > 1) ? $clog2(READERS) : 1;
	localparam int unsigned SW = (DATA_BITS < WORD_BITS) ? DATA_BITS : WORD_BITS;
	localparam int unsigned XW = RDR_BITS + 3;

	logic                   mode_q;
	logic [RDR_BITS-1:0]    reader_q;
	logic [SW-1:0]          din_q;
	logic [DEPTH-1:0]       used_q;
	logic [IW-1:0]          widx_q;
	logic [COUNT_BITS-1:0]  sent_q;
	logic [COUNT_BITS-1:0]  cnt_q [READERS];
	logic [COUNT_BITS-1:0]  lagn_q;
	logic [IW-1:0]          slot_q;
	logic [READERS-1:0]     flags_q;
	logic                   done_q;
	logic [1:0]             status_q;
	logic [WORD_BITS-1:0]   dout_q;
	logic                   freed_q;

	logic [IW-1:0]          mod_tab [2**COUNT_BITS];
	logic [XW-1:0]          rdr_ext;
	logic [RI-1:0]          ridx;
	logic                   reader_ok;
	logic [COUNT_BITS-1:0]  cnt_rd;
	logic [COUNT_BITS-1:0]  lag_w;
	logic [IW-1:0]          lag_mod;
	logic [IW:0]            slot_sum;
	logic [IW-1:0]          slot_w;
	logic                   full_w;
	logic                   is_send;
	logic                   ram_we;
	logic                   ram_re;
	logic [SW-1:0]          ram_rd;
	logic                   pending;

	for (genvar g = 0; g < 2**COUNT_BITS; g++) begin : g_mod
		localparam int unsigned MV = g % DEPTH;
		assign mod_tab[g] = IW'(MV);
	end

	assign rdr_ext   = XW'(reader_q);
	assign ridx      = rdr_ext[RI-1:0];
	assign reader_ok = (32'(reader_q) < 32'(READERS));
	assign cnt_rd    = cnt_q[ridx];
	assign lag_w     = sent_q - cnt_rd;
	assign lag_mod   = mod_tab[lag_w];
	assign slot_sum  = (IW+1)'(widx_q) + (IW+1)'(DEPTH) - (IW+1)'(lag_mod);
	assign slot_w    = (slot_sum >= (IW+1)'(DEPTH)) ?
		IW'(slot_sum - (IW+1)'(DEPTH)) : IW'(slot_sum);
	assign full_w    = used_q[widx_q];
	assign is_send   = (mode_q == MODE_SEND);

	assign stat.recv_go = !is_send && reader_ok && (lag_w != '0);

	assign ram_we  = cmd.exec && is_send && !full_w;
	assign ram_re  = cmd.exec && stat.recv_go;
	assign pending = |flags_q;

	brb_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_q),
		.wdata (din_q),
		.re    (ram_re),
		.raddr (slot_w),
		.rdata (ram_rd)
	);

	// request payload, scratch values and result fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			reader_q <= reader;
			din_q    <= data_in[SW-1:0];
		end
		if (ram_re) begin
			lagn_q <= lag_w - COUNT_BITS'(1);
			slot_q <= slot_w;
		end
		if (cmd.flag) begin
			for (int i = 0; i < READERS; i++) begin
				flags_q[i] <= (sent_q - cnt_q[i]) > lagn_q;
			end
		end
		if (cmd.exec && !stat.recv_go) begin
			status_q <= is_send ? (full_w ? ST_FULL : ST_DONE) : ST_EMPTY;
			dout_q   <= '0;
			freed_q  <= 1'b0;
		end else if (cmd.finish) begin
			status_q <= ST_DONE;
			dout_q   <= WORD_BITS'(ram_rd);
			freed_q  <= !pending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			widx_q <= '0;
			sent_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < READERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			done_q <= (cmd.exec && !stat.recv_go) || cmd.finish;
			if (ram_we) begin
				used_q[widx_q] <= 1'b1;
				widx_q <= (widx_q == IW'(DEPTH - 1)) ? '0 : widx_q + IW'(1);
				sent_q <= sent_q + COUNT_BITS'(1);
			end
			if (ram_re) begin
				cnt_q[ridx] <= cnt_rd + COUNT_BITS'(1);
			end
			if (cmd.finish && !pending) begin
				used_q[slot_q] <= 1'b0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign data_out   = dout_q;
	assign slot_freed = freed_q;
endmodule

// ===== tb/sv/brb_ring_check.sv =====
// Watches the request and result channels, predicts each result and counts mismatches.
`timescale 1ns / 1ps
module brb_ring_check
	import brb_pkg::*;
#(
	parameter int unsigned DEPTH   = DEPTH_DEF,
	parameter int unsigned READERS = READERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 mode,
	input  logic [RDR_BITS-1:0]  reader,
	input  logic [WORD_BITS-1:0] data_in,
	input  logic                 done,
	input  logic [1:0]           status,
	input  logic [WORD_BITS-1:0] data_out,
	input  logic                 slot_freed,
	output int                   errors,
	output int                   pending
);
	typedef struct packed {
		logic [1:0]           status;
		logic [WORD_BITS-1:0] word;
		logic                 freed;
	} outcome_t;

	logic [WORD_BITS-1:0]  ring_word [DEPTH];
	logic                  ring_used [DEPTH];
	int unsigned           wr_idx;
	logic [COUNT_BITS-1:0] sent_cnt;
	logic [COUNT_BITS-1:0] rd_cnt [READERS];
	outcome_t              due_q [$];
	int                    err_cnt = 0;

	// Applies one request to the local copy of the buffer and returns its result.
	function automatic outcome_t serve(input logic m, input logic [RDR_BITS-1:0] who,
			input logic [WORD_BITS-1:0] word);
		outcome_t              o;
		logic [COUNT_BITS-1:0] lag;
		logic [COUNT_BITS-1:0] other;
		int unsigned           slot;
		logic                  behind;
		o.status = ST_DONE;
		o.word   = '0;
		o.freed  = 1'b0;
		if (m == MODE_SEND) begin
			if (ring_used[wr_idx]) begin
				o.status = ST_FULL;
			end else begin
				ring_word[wr_idx] = word;
				ring_used[wr_idx] = 1'b1;
				wr_idx = (wr_idx + 1) % DEPTH;
				sent_cnt = sent_cnt + 1'b1;
			end
		end else if (int'(who) >= int'(READERS)) begin
			o.status = ST_EMPTY;
		end else begin
			lag = sent_cnt - rd_cnt[who];
			if (lag == '0) begin
				o.status = ST_EMPTY;
			end else begin
				slot = (wr_idx + DEPTH - (lag % DEPTH)) % DEPTH;
				o.word = ring_word[slot];
				rd_cnt[who] = rd_cnt[who] + 1'b1;
				lag = lag - 1'b1;
				behind = 1'b0;
				for (int i = 0; i < READERS; i++) begin
					other = sent_cnt - rd_cnt[i];
					if (other > lag)
						behind = 1'b1;
				end
				// last reader past this word releases the slot
				if (!behind) begin
					ring_used[slot] = 1'b0;
					o.freed = 1'b1;
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				ring_used[i] = 1'b0;
			for (int i = 0; i < READERS; i++)
				rd_cnt[i] = '0;
			wr_idx = 0;
			sent_cnt = '0;
			due_q.delete();
			pending <= 0;
			errors <= err_cnt;
		end else begin
			if (done) begin
				if (due_q.size() == 0) begin
					$display("%0t: result with no request waiting: status %0d data %h freed %0b",
						$time, status, data_out, slot_freed);
					err_cnt++;
				end else begin
					exp = due_q.pop_front();
					if (status !== exp.status) begin
						$display("%0t: status expected %0d actual %0d", $time, exp.status, status);
						err_cnt++;
					end
					if (data_out !== exp.word) begin
						$display("%0t: data_out expected %h actual %h", $time, exp.word, data_out);
						err_cnt++;
					end
					if (slot_freed !== exp.freed) begin
						$display("%0t: slot_freed expected %0b actual %0b", $time, exp.freed,
							slot_freed);
						err_cnt++;
					end
				end
			end
			if (start && !busy)
				due_q = {due_q, serve(mode, reader, data_in)};
			pending <= due_q.size();
			errors <= err_cnt;
		end
	end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, request stimulus for the ring buffer and the verdict.
`timescale 1ns / 1ps
module tb_top;
	import brb_pkg::*;

	localparam int GAP_MAX = 8;
	localparam int ITEMS   = 1600;
	localparam int TAIL    = 8;
	localparam int LIMIT   = 250000;

	typedef struct packed {
		logic                 mode;
		logic [RDR_BITS-1:0]  who;
		logic [WORD_BITS-1:0] word;
	} request_t;

	logic                 clk;
	logic                 arst_n  = 1'b0;
	logic                 start   = 1'b0;
	logic                 mode    = MODE_SEND;
	logic [RDR_BITS-1:0]  reader  = '0;
	logic [WORD_BITS-1:0] data_in = '0;
	logic                 busy;
	logic                 done;
	logic [1:0]           status;
	logic [WORD_BITS-1:0] data_out;
	logic                 slot_freed;
	int                   errors;
	int                   pending;
	int unsigned          cycles = 0;
	int                   issued = 0;
	request_t             batch [$];

	broadcast_ring_buffer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.reader     (reader),
		.data_in    (data_in),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.slot_freed (slot_freed)
	);

	brb_ring_check ring_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.reader     (reader),
		.data_in    (data_in),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.slot_freed (slot_freed),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic logic [WORD_BITS-1:0] pick_word();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return WORD_BITS'($urandom);
	endfunction

	// Called at a clock edge; returns at the edge where the request is taken.
	task automatic issue(input logic m, input logic [RDR_BITS-1:0] who,
			input logic [WORD_BITS-1:0] word, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		mode    <= m;
		reader  <= who;
		data_in <= word;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		issued++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int       k;
		int       gmax;
		int       j;
		request_t tmp;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty read, fill all slots with extreme and random words, overflow, then every reader once
		issue(MODE_RECV, '0, '1, $urandom_range(0, GAP_MAX));
		issue(MODE_SEND, '1, '0, $urandom_range(0, GAP_MAX));
		issue(MODE_SEND, '0, '1, $urandom_range(0, GAP_MAX));
		issue(MODE_SEND, '0, 32'hAAAA_AAAA, $urandom_range(0, GAP_MAX));
		issue(MODE_SEND, '0, 32'h5555_5555, $urandom_range(0, GAP_MAX));
		repeat (4)
			issue(MODE_SEND, RDR_BITS'($urandom), WORD_BITS'($urandom), 0);
		issue(MODE_SEND, '0, 32'h1234_5678, $urandom_range(0, GAP_MAX));
		for (int r = READERS_DEF - 1; r >= 0; r--)
			issue(MODE_RECV, RDR_BITS'(r), '0, $urandom_range(0, GAP_MAX));
		drain();

		while (issued < ITEMS) begin
			gmax = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			batch.delete();
			if ($urandom_range(0, 9) < 7) begin
				// k sends, then each reader takes about k words; the order is shuffled half the time
				k = $urandom_range(1, DEPTH_DEF);
				repeat (k) begin
					tmp.mode = MODE_SEND;
					tmp.who  = RDR_BITS'($urandom);
					tmp.word = pick_word();
					batch = {batch, tmp};
				end
				for (int r = 0; r < READERS_DEF; r++) begin
					repeat ($urandom_range(k - 1, k + 1)) begin
						tmp.mode = MODE_RECV;
						tmp.who  = RDR_BITS'(r);
						tmp.word = WORD_BITS'($urandom);
						batch = {batch, tmp};
					end
				end
				if ($urandom_range(0, 1) == 1) begin
					for (j = batch.size() - 1; j > 0; j--) begin
						k = $urandom_range(0, j);
						tmp = batch[j];
						batch[j] = batch[k];
						batch[k] = tmp;
					end
				end
			end else begin
				repeat ($urandom_range(4, 20)) begin
					tmp.mode = ($urandom_range(0, 1) == 1) ? MODE_RECV : MODE_SEND;
					tmp.who  = RDR_BITS'($urandom);
					tmp.word = pick_word();
					batch = {batch, tmp};
				end
			end
			foreach (batch[i])
				issue(batch[i].mode, batch[i].who, batch[i].word, $urandom_range(0, gmax));
			if ($urandom_range(0, 11) == 0)
				drain();
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
